### src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("property does not hold");
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_HOLDS(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

### src/dwps_pkg.sv
package dwps_pkg;

   localparam int SPEED_W      = 16;
   localparam int DELTA_W      = SPEED_W + 1;
   localparam int GAIN_W       = 16;
   localparam int ACC_W        = 32;
   localparam int PSUM_W       = 34;
   localparam int FRAC_W       = 8;
   localparam int DRIVE_W      = 24;
   localparam int DUTY_W       = 13;
   localparam int FLAGS_W      = 9;
   localparam int STAGE_W      = 3;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 64;
   localparam int QUEUE_DEPTH  = 2;
   localparam int DUTY_LIMIT_DEFAULT = 8000;

   // road flag bit positions
   localparam int FLAG_STRAIGHT = 0;
   localparam int FLAG_BEND     = 1;
   localparam int FLAG_CROSS    = 2;
   localparam int FLAG_FORK     = 3;
   localparam int FLAG_RING_L   = 4;
   localparam int FLAG_RING_R   = 5;
   localparam int FLAG_LEAN_L   = 6;
   localparam int FLAG_LEAN_R   = 7;
   localparam int FLAG_STOP     = 8;

   localparam logic [STAGE_W-1:0] BARN_PASS_STAGE = 3'd2;
   localparam logic [STAGE_W-1:0] RING_TIGHT_STAGE = 3'd3;
   localparam logic [STAGE_W-1:0] RING_IDLE_STAGE  = 3'd0;

   localparam logic signed [SPEED_W-1:0] FORK_OFF_SLOW  = -16'sd50;
   localparam logic signed [SPEED_W-1:0] FORK_OFF_FAST  = 16'sd30;
   localparam logic signed [SPEED_W-1:0] RING_OFF_TIGHT = 16'sd20;
   localparam logic signed [SPEED_W-1:0] RING_OFF_OPEN  = 16'sd50;
   localparam logic signed [SPEED_W-1:0] LEAN_OFF_FAST  = 16'sd70;
   localparam logic signed [SPEED_W-1:0] LEAN_OFF_SLOW  = -16'sd80;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_LEFT_KP      = 3'd0,
      REG_LEFT_KI      = 3'd1,
      REG_RIGHT_KP     = 3'd2,
      REG_RIGHT_KI     = 3'd3,
      REG_TARGETS_LOW  = 3'd4,
      REG_TARGETS_HIGH = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic                   valid;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_write_type;

   typedef struct packed {
      logic signed [SPEED_W-1:0] left_error;
      logic signed [SPEED_W-1:0] right_error;
      logic signed [DELTA_W-1:0] left_delta;
      logic signed [DELTA_W-1:0] right_delta;
      logic signed [SPEED_W-1:0] mean_speed;
   } work_type;

endpackage

### src/dwps_front.sv
module dwps_front
   import dwps_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  csr_write_type             csr,
   input  logic                      push,
   input  logic [FLAGS_W-1:0]        road_flags,
   input  logic [STAGE_W-1:0]        barn_stage,
   input  logic [STAGE_W-1:0]        fork_stage,
   input  logic [STAGE_W-1:0]        ring_stage,
   input  logic [STAGE_W-1:0]        lean_stage,
   input  logic signed [SPEED_W-1:0] left_pulses,
   input  logic signed [SPEED_W-1:0] right_pulses_raw,
   output work_type                  entry
);

   logic [CSR_DATA_W-1:0]     targets_low_ff, targets_low_in;
   logic [CSR_DATA_W-1:0]     targets_high_ff, targets_high_in;
   logic signed [SPEED_W-1:0] left_prev_ff, left_prev_in;
   logic signed [SPEED_W-1:0] right_prev_ff, right_prev_in;

   logic                      hit;
   logic signed [SPEED_W-1:0] target;
   logic signed [SPEED_W-1:0] right_speed;
   logic signed [SPEED_W-1:0] left_err;
   logic signed [SPEED_W-1:0] right_err;
   logic signed [DELTA_W-1:0] speed_sum;
   logic signed [DELTA_W-1:0] speed_sum_adj;

   always_comb begin
      targets_low_in  = targets_low_ff;
      targets_high_in = targets_high_ff;
      if (csr.valid) begin
         case (csr_reg_type'(csr.index))
            REG_TARGETS_LOW:  targets_low_in  = csr.data;
            REG_TARGETS_HIGH: targets_high_in = csr.data;
            default: ;
         endcase
      end
   end

   // priority chain; a branch with an unused stage ends the search with no target
   always_comb begin
      hit    = 1'b0;
      target = '0;
      if (road_flags[FLAG_STRAIGHT]) begin
         hit    = 1'b1;
         target = targets_low_ff[15:0];
      end else if (road_flags[FLAG_BEND]) begin
         hit    = 1'b1;
         target = targets_low_ff[31:16];
      end else if (road_flags[FLAG_CROSS]) begin
         hit    = 1'b1;
         target = targets_low_ff[47:32];
      end else if (road_flags[FLAG_FORK]) begin
         target = targets_low_ff[63:48];
         case (fork_stage)
            3'd1, 3'd4: begin
               hit    = 1'b1;
               target = targets_low_ff[63:48] + FORK_OFF_SLOW;
            end
            3'd2, 3'd5: hit = 1'b1;
            3'd3: begin
               hit    = 1'b1;
               target = targets_low_ff[63:48] + FORK_OFF_FAST;
            end
            default: hit = 1'b0;
         endcase
      end else if (road_flags[FLAG_RING_L] || road_flags[FLAG_RING_R]) begin
         hit = (ring_stage != RING_IDLE_STAGE);
         if (ring_stage == RING_TIGHT_STAGE) begin
            target = targets_high_ff[15:0] + RING_OFF_TIGHT;
         end else begin
            target = targets_high_ff[15:0] + RING_OFF_OPEN;
         end
      end else if (road_flags[FLAG_LEAN_L] || road_flags[FLAG_LEAN_R]) begin
         target = targets_high_ff[31:16];
         case (lean_stage)
            3'd1: hit = 1'b1;
            3'd2: begin
               hit    = 1'b1;
               target = targets_high_ff[31:16] + LEAN_OFF_FAST;
            end
            3'd3: begin
               hit    = 1'b1;
               target = targets_high_ff[31:16] + LEAN_OFF_SLOW;
            end
            default: hit = 1'b0;
         endcase
      end else if (barn_stage == BARN_PASS_STAGE) begin
         hit    = 1'b1;
         target = targets_high_ff[47:32];
      end else if (road_flags[FLAG_STOP]) begin
         hit    = 1'b1;
         target = targets_high_ff[63:48];
      end
   end

   always_comb begin
      right_speed   = -right_pulses_raw;
      left_err      = hit ? target - left_pulses : '0;
      right_err     = hit ? target - right_speed : '0;
      speed_sum     = DELTA_W'(left_pulses) + DELTA_W'(right_speed);
      // round toward zero before halving
      speed_sum_adj = speed_sum + (speed_sum[DELTA_W-1] ? DELTA_W'(1) : DELTA_W'(0));

      entry.left_error  = left_err;
      entry.right_error = right_err;
      entry.left_delta  = DELTA_W'(left_err) - DELTA_W'(left_prev_ff);
      entry.right_delta = DELTA_W'(right_err) - DELTA_W'(right_prev_ff);
      entry.mean_speed  = speed_sum_adj[DELTA_W-1:1];

      left_prev_in  = push ? left_err : left_prev_ff;
      right_prev_in = push ? right_err : right_prev_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         targets_low_ff  <= '0;
         targets_high_ff <= '0;
         left_prev_ff    <= '0;
         right_prev_ff   <= '0;
      end else begin
         targets_low_ff  <= targets_low_in;
         targets_high_ff <= targets_high_in;
         left_prev_ff    <= left_prev_in;
         right_prev_ff   <= right_prev_in;
      end
   end

endmodule

### src/dwps_queue.sv
`include "assert_macros.svh"

module dwps_queue
   import dwps_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_data,
   output logic     full,
   input  logic     pop,
   output logic     pop_valid,
   output work_type pop_data
);

   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   work_type            slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]  count_ff, count_in;

   always_comb begin
      full      = (count_ff == COUNT_W'(QUEUE_DEPTH));
      pop_valid = (count_ff != '0);
      pop_data  = slots_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `ASSERT_NEVER(a_queue_overfill, clock, reset, count_ff > COUNT_W'(QUEUE_DEPTH))
   `ASSERT_HOLDS(a_queue_grows, clock, reset, push && !pop |=> count_ff == $past(count_ff) + 1'b1)

endmodule

### src/dwps_back.sv
`include "assert_macros.svh"

module dwps_back
   import dwps_pkg::*;
#(
   parameter int DUTY_LIMIT = DUTY_LIMIT_DEFAULT
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  csr_write_type              csr,
   input  logic                       queue_valid,
   input  work_type                   queue_data,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SPEED_W-1:0]  rsp_left_error,
   output logic signed [SPEED_W-1:0]  rsp_right_error,
   output logic signed [DRIVE_W-1:0]  rsp_left_drive,
   output logic signed [DRIVE_W-1:0]  rsp_right_drive,
   output logic [DUTY_W-1:0]          rsp_left_fwd_duty,
   output logic [DUTY_W-1:0]          rsp_left_rev_duty,
   output logic [DUTY_W-1:0]          rsp_right_fwd_duty,
   output logic [DUTY_W-1:0]          rsp_right_rev_duty,
   output logic signed [SPEED_W-1:0]  rsp_mean_speed
);

   localparam int SUM_W = PSUM_W + 1;
   localparam logic signed [DRIVE_W:0] LIMIT = (DRIVE_W + 1)'(DUTY_LIMIT);
   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef struct packed {
      logic [DUTY_W-1:0] fwd;
      logic [DUTY_W-1:0] rev;
   } duty_type;

   function automatic duty_type split_duty(input logic signed [DRIVE_W-1:0] drive);
      duty_type                  d;
      logic signed [DRIVE_W:0]   wide;
      logic signed [DRIVE_W:0]   mag;
      wide = (DRIVE_W + 1)'(drive);
      mag  = -wide;
      d    = '0;
      if (wide > 0) begin
         d.fwd = (wide > LIMIT) ? LIMIT[DUTY_W-1:0] : wide[DUTY_W-1:0];
      end else begin
         d.rev = (mag > LIMIT) ? LIMIT[DUTY_W-1:0] : mag[DUTY_W-1:0];
      end
      return d;
   endfunction

   function automatic logic signed [ACC_W-1:0] sat_add(
      input logic signed [ACC_W-1:0]  acc,
      input logic signed [PSUM_W-1:0] inc
   );
      logic signed [SUM_W-1:0] s;
      s = SUM_W'(acc) + SUM_W'(inc);
      if (s[SUM_W-1:ACC_W-1] == '0 || s[SUM_W-1:ACC_W-1] == '1) begin
         return s[ACC_W-1:0];
      end
      return s[SUM_W-1] ? ACC_MIN : ACC_MAX;
   endfunction

   logic [GAIN_W-1:0] left_kp_ff, left_kp_in, left_ki_ff, left_ki_in;
   logic [GAIN_W-1:0] right_kp_ff, right_kp_in, right_ki_ff, right_ki_in;

   logic                      p_valid_ff, p_valid_in;
   logic signed [PSUM_W-1:0]  p_left_sum_ff, p_left_sum_in;
   logic signed [PSUM_W-1:0]  p_right_sum_ff, p_right_sum_in;
   work_type                  p_entry_ff;

   logic signed [ACC_W-1:0]   left_acc_ff, left_acc_in;
   logic signed [ACC_W-1:0]   right_acc_ff, right_acc_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [SPEED_W-1:0] rsp_left_error_ff, rsp_right_error_ff, rsp_mean_speed_ff;
   logic signed [DRIVE_W-1:0] rsp_left_drive_ff, rsp_right_drive_ff;
   duty_type                  rsp_left_duty_ff, rsp_right_duty_ff;

   logic                      advance;
   logic signed [GAIN_W:0]    left_kp_s, left_ki_s, right_kp_s, right_ki_s;
   logic signed [PSUM_W-1:0]  left_prop, left_int, right_prop, right_int;
   logic signed [ACC_W-1:0]   left_acc_next, right_acc_next;

   always_comb begin
      left_kp_in  = left_kp_ff;
      left_ki_in  = left_ki_ff;
      right_kp_in = right_kp_ff;
      right_ki_in = right_ki_ff;
      if (csr.valid) begin
         case (csr_reg_type'(csr.index))
            REG_LEFT_KP:  left_kp_in  = csr.data[GAIN_W-1:0];
            REG_LEFT_KI:  left_ki_in  = csr.data[GAIN_W-1:0];
            REG_RIGHT_KP: right_kp_in = csr.data[GAIN_W-1:0];
            REG_RIGHT_KI: right_ki_in = csr.data[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // product stage: kp*(e - prev) + ki*e per wheel
   always_comb begin
      left_kp_s  = $signed({1'b0, left_kp_ff});
      left_ki_s  = $signed({1'b0, left_ki_ff});
      right_kp_s = $signed({1'b0, right_kp_ff});
      right_ki_s = $signed({1'b0, right_ki_ff});
      left_prop  = PSUM_W'(left_kp_s) * PSUM_W'(queue_data.left_delta);
      left_int   = PSUM_W'(left_ki_s) * PSUM_W'(queue_data.left_error);
      right_prop = PSUM_W'(right_kp_s) * PSUM_W'(queue_data.right_delta);
      right_int  = PSUM_W'(right_ki_s) * PSUM_W'(queue_data.right_error);
      p_left_sum_in  = left_prop + left_int;
      p_right_sum_in = right_prop + right_int;
   end

   always_comb begin
      advance        = !rsp_valid_ff || !rsp_stall;
      pop            = advance && queue_valid;
      p_valid_in     = advance ? queue_valid : p_valid_ff;
      rsp_valid_in   = advance ? p_valid_ff : rsp_valid_ff;
      left_acc_next  = sat_add(left_acc_ff, p_left_sum_ff);
      right_acc_next = sat_add(right_acc_ff, p_right_sum_ff);
      left_acc_in    = (advance && p_valid_ff) ? left_acc_next : left_acc_ff;
      right_acc_in   = (advance && p_valid_ff) ? right_acc_next : right_acc_ff;
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         p_left_sum_ff  <= p_left_sum_in;
         p_right_sum_ff <= p_right_sum_in;
         p_entry_ff     <= queue_data;
      end
      if (advance && p_valid_ff) begin
         rsp_left_error_ff  <= p_entry_ff.left_error;
         rsp_right_error_ff <= p_entry_ff.right_error;
         rsp_mean_speed_ff  <= p_entry_ff.mean_speed;
         rsp_left_drive_ff  <= left_acc_next[ACC_W-1:FRAC_W];
         rsp_right_drive_ff <= right_acc_next[ACC_W-1:FRAC_W];
         rsp_left_duty_ff   <= split_duty(left_acc_next[ACC_W-1:FRAC_W]);
         rsp_right_duty_ff  <= split_duty(right_acc_next[ACC_W-1:FRAC_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_kp_ff   <= '0;
         left_ki_ff   <= '0;
         right_kp_ff  <= '0;
         right_ki_ff  <= '0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         left_acc_ff  <= '0;
         right_acc_ff <= '0;
      end else begin
         left_kp_ff   <= left_kp_in;
         left_ki_ff   <= left_ki_in;
         right_kp_ff  <= right_kp_in;
         right_ki_ff  <= right_ki_in;
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         left_acc_ff  <= left_acc_in;
         right_acc_ff <= right_acc_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_left_error     = rsp_left_error_ff;
   assign rsp_right_error    = rsp_right_error_ff;
   assign rsp_left_drive     = rsp_left_drive_ff;
   assign rsp_right_drive    = rsp_right_drive_ff;
   assign rsp_left_fwd_duty  = rsp_left_duty_ff.fwd;
   assign rsp_left_rev_duty  = rsp_left_duty_ff.rev;
   assign rsp_right_fwd_duty = rsp_right_duty_ff.fwd;
   assign rsp_right_rev_duty = rsp_right_duty_ff.rev;
   assign rsp_mean_speed     = rsp_mean_speed_ff;

   `ASSERT_HOLDS(a_acc_holds, clock, reset, !(advance && p_valid_ff) |=> $stable(left_acc_ff) && $stable(right_acc_ff))
   `ASSERT_HOLDS(a_drive_tracks_acc, clock, reset, rsp_valid_ff |-> rsp_left_drive_ff == left_acc_ff[ACC_W-1:FRAC_W] && rsp_right_drive_ff == right_acc_ff[ACC_W-1:FRAC_W])

endmodule

### src/dual_wheel_incremental_pi_speed.sv
// Two-wheel incremental PI speed loop, one request per control tick.
// Request channel (req_*): road flags, stage numbers and both encoder counts;
// taken at a clock edge with req_valid high and req_stall low.
// Response channel (rsp_*): wheel errors, accumulator integer parts, forward and
// reverse PWM duties and the mean speed; taken with rsp_valid high, rsp_stall low.
// Register port (csr_*): gains and target table, written with csr_valid and
// csr_ready high; csr_ready is always high. Write only while no request is in flight.
// A request is registered in the queue, then in the product registers, then in the response registers.
// Throughput: one request per cycle while rsp_stall stays low; the accumulator add
// and saturate loops through its own register; the products are computed a stage earlier.
// A two-entry queue separates the target/error front end from the PI back end;
// when rsp_stall holds, the back end freezes, the queue fills and req_stall rises.
// Reset (synchronous) clears gains, targets, accumulators, previous errors and
// all valid flags; no response is pending afterwards.
module dual_wheel_incremental_pi_speed
   import dwps_pkg::*;
#(
   parameter int DUTY_LIMIT = DUTY_LIMIT_DEFAULT
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [FLAGS_W-1:0]         req_road_flags,
   input  logic [STAGE_W-1:0]         req_barn_stage,
   input  logic [STAGE_W-1:0]         req_fork_stage,
   input  logic [STAGE_W-1:0]         req_ring_stage,
   input  logic [STAGE_W-1:0]         req_lean_stage,
   input  logic signed [SPEED_W-1:0]  req_left_pulses,
   input  logic signed [SPEED_W-1:0]  req_right_pulses_raw,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SPEED_W-1:0]  rsp_left_error,
   output logic signed [SPEED_W-1:0]  rsp_right_error,
   output logic signed [DRIVE_W-1:0]  rsp_left_drive,
   output logic signed [DRIVE_W-1:0]  rsp_right_drive,
   output logic [DUTY_W-1:0]          rsp_left_fwd_duty,
   output logic [DUTY_W-1:0]          rsp_left_rev_duty,
   output logic [DUTY_W-1:0]          rsp_right_fwd_duty,
   output logic [DUTY_W-1:0]          rsp_right_rev_duty,
   output logic signed [SPEED_W-1:0]  rsp_mean_speed,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data
);

   csr_write_type csr;
   work_type      front_entry;
   work_type      queue_data;
   logic          queue_full;
   logic          queue_valid;
   logic          push;
   logic          pop;

   assign csr_ready = 1'b1;
   assign csr.valid = csr_valid;
   assign csr.index = csr_index;
   assign csr.data  = csr_data;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   dwps_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr              (csr),
      .push             (push),
      .road_flags       (req_road_flags),
      .barn_stage       (req_barn_stage),
      .fork_stage       (req_fork_stage),
      .ring_stage       (req_ring_stage),
      .lean_stage       (req_lean_stage),
      .left_pulses      (req_left_pulses),
      .right_pulses_raw (req_right_pulses_raw),
      .entry            (front_entry)
   );

   dwps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_entry),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (queue_valid),
      .pop_data  (queue_data)
   );

   dwps_back #(
      .DUTY_LIMIT (DUTY_LIMIT)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .csr                (csr),
      .queue_valid        (queue_valid),
      .queue_data         (queue_data),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_left_error     (rsp_left_error),
      .rsp_right_error    (rsp_right_error),
      .rsp_left_drive     (rsp_left_drive),
      .rsp_right_drive    (rsp_right_drive),
      .rsp_left_fwd_duty  (rsp_left_fwd_duty),
      .rsp_left_rev_duty  (rsp_left_rev_duty),
      .rsp_right_fwd_duty (rsp_right_fwd_duty),
      .rsp_right_rev_duty (rsp_right_rev_duty),
      .rsp_mean_speed     (rsp_mean_speed)
   );

endmodule
